// ===== rtl/sorted_key_set_top_assert.svh =====
// assertion macros for the sorted key set top level
// no dependencies; included by sorted_key_set_top.sv
`ifndef SORTED_KEY_SET_TOP_ASSERT_SVH
`define SORTED_KEY_SET_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check with reset disabling the property
`define SKS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define SKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/skset_pkg.sv =====
// shared types and codes for the sorted key set
// no dependencies; used by every module of the block
package skset_pkg;

  localparam int FIELD_W = 30;
  localparam int CODE_W  = 6;

  // command codes; code 3 is a no-op
  typedef enum logic [1:0] {
    CMD_ENTER  = 2'd0,
    CMD_LEAVE  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ENTRY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] name_key;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FIELD_W-1:0] key_out;
    logic               has_key;
    logic               last;
  } out_req_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
  } cell_op_t;

endpackage

// ===== rtl/skset_cell.sv =====
// one cell of the descending key chain: holds a key and its valid bit
// depends on skset_pkg
module skset_cell
  import skset_pkg::*;
#(
  parameter int KEY_W = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_op_t         op_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic             left_valid_i,
  input  logic             left_gt_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic             right_valid_i,
  input  logic [KEY_W-1:0] head_key_i,
  output logic [KEY_W-1:0] key_o,
  output logic             valid_o,
  output logic             gt_o,
  output logic             eq_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid_q, valid_d;

  // compare against the broadcast key
  assign gt_o    = valid_q && (key_q > key_i);
  assign eq_o    = valid_q && (key_q == key_i);
  assign key_o   = key_q;
  assign valid_o = valid_q;

  // next cell contents
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (op_i.ins && !gt_o) begin
      // first cell not above the new key takes it, the rest shift down
      if (left_gt_i) begin
        key_d   = key_i;
        valid_d = 1'b1;
      end else begin
        key_d   = left_key_i;
        valid_d = left_valid_i;
      end
    end else if (op_i.del && !gt_o) begin
      // close the gap from the right neighbor
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (op_i.rot && valid_q) begin
      // rotate the stored keys, the head wraps to the last stored cell
      if (right_valid_i) begin
        key_d = right_key_i;
      end else begin
        key_d = head_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== rtl/skset_chain.sv =====
// row of key cells kept in descending order, cell 0 holds the largest key
// depends on skset_pkg and skset_cell
module skset_chain
  import skset_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int KEY_W    = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_op_t         op_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             found_o,
  output logic [KEY_W-1:0] head_key_o
);

  logic [KEY_W-1:0]    cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_eq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    logic             left_valid, left_gt, right_valid;

    // neighbor wiring, the ends see an empty boundary
    if (i == 0) begin : g_first
      assign left_key   = '0;
      assign left_valid = 1'b0;
      assign left_gt    = 1'b1;
    end else begin : g_inner_l
      assign left_key   = cell_key[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_key   = cell_key[i+1];
      assign right_valid = cell_valid[i+1];
    end

    skset_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op_i),
      .key_i        (key_i),
      .left_key_i   (left_key),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_key_i  (right_key),
      .right_valid_i(right_valid),
      .head_key_i   (cell_key[0]),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  assign found_o    = |cell_eq;
  assign head_key_o = cell_key[0];

endmodule

// ===== rtl/sorted_key_set_top.sv =====
// Sorted key set: holds up to CAPACITY name keys in a chain of cells kept in
// descending order. Enter, leave and the unused code each give one result; the
// compare and shift of the whole chain happen in the cycle the result is loaded.
// Report gives one entry per stored key (one closing entry for an empty set) as
// keys leave through cell 0 and the chain rotates one cell per result, pausing
// on an output stall. Inputs stall while a report drains or while the output
// register holds a result that is not taken. No clearing pass after reset.
// depends on skset_pkg, skset_chain and sorted_key_set_top_assert.svh
`include "sorted_key_set_top_assert.svh"
module sorted_key_set_top
  import skset_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int NAME_CHARS = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int KEY_W = (CODE_W * NAME_CHARS < FIELD_W) ? CODE_W * NAME_CHARS : FIELD_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             rpt_active_q, rpt_active_d;
  logic             out_valid_q, out_valid_d;
  out_req_t         out_req_q, res;
  logic             load;
  logic             out_ready;
  logic             accept;
  logic             found;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] head_key;
  cell_op_t         op;
  logic             drain_ok;
  logic             enter_new;

  assign key        = in_req_i.name_key[KEY_W-1:0];
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = rpt_active_q || !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  skset_chain #(
    .CAPACITY(CAPACITY),
    .KEY_W   (KEY_W)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .key_i     (key),
    .found_o   (found),
    .head_key_o(head_key)
  );

  // command decode and report drain
  always_comb begin
    op           = '0;
    res          = '0;
    res.last     = 1'b1;
    load         = 1'b0;
    count_d      = count_q;
    left_d       = left_q;
    rpt_active_d = rpt_active_q;
    if (rpt_active_q) begin
      if (out_ready) begin
        load         = 1'b1;
        res.status   = ST_ENTRY;
        res.key_out  = FIELD_W'(head_key);
        res.has_key  = 1'b1;
        res.last     = (left_q == CNT_W'(1));
        op.rot       = 1'b1;
        left_d       = left_q - CNT_W'(1);
        rpt_active_d = (left_q != CNT_W'(1));
      end
    end else if (accept) begin
      case (in_req_i.command)
        CMD_ENTER: begin
          load = 1'b1;
          if (found) begin
            res.status = ST_DUP;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_DONE;
            op.ins     = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
        end
        CMD_LEAVE: begin
          load = 1'b1;
          if (found) begin
            res.status = ST_DONE;
            op.del     = 1'b1;
            count_d    = count_q - CNT_W'(1);
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
        CMD_REPORT: begin
          if (count_q == '0) begin
            load       = 1'b1;
            res.status = ST_ENTRY;
          end else begin
            rpt_active_d = 1'b1;
            left_d       = count_q;
          end
        end
        default: begin
          load       = 1'b1;
          res.status = ST_DONE;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      left_q       <= '0;
      rpt_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      left_q       <= left_d;
      rpt_active_q <= rpt_active_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // checks
  assign drain_ok  = (left_q != '0) && (left_q <= count_q);
  assign enter_new = accept && (in_req_i.command == CMD_ENTER) && !found &&
                     (count_q != CNT_W'(CAPACITY));

  `SKS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `SKS_ASSERT(a_drain_len, clk_i, rst_ni, rpt_active_q |-> drain_ok, "bad report drain length")
  `SKS_ASSERT(a_enter_grows, clk_i, rst_ni, enter_new |=> (count_q == $past(count_q) + CNT_W'(1)), "enter did not grow")

endmodule

// ===== sim/sorted_key_set_top_tb.sv =====
// self-checking testbench for sorted_key_set_top: directed and random requests
// against a predictor of the sorted key set, with random idling on both channels
// depends on skset_pkg and sorted_key_set_top
`timescale 1ns / 1ps

// predictor of the key set and store of the results still to come
class sorted_set_predictor;
  int unsigned                  capacity;
  logic [skset_pkg::FIELD_W-1:0] key_mask;
  // stored keys, ascending
  logic [skset_pkg::FIELD_W-1:0] stored_keys[$];
  skset_pkg::out_req_t          pending_results[$];
  int unsigned                  n_errors;

  function new(int unsigned capacity_i, int unsigned name_chars_i);
    capacity = capacity_i;
    key_mask = skset_pkg::FIELD_W'((64'd1 << (skset_pkg::CODE_W * name_chars_i)) - 64'd1);
    n_errors = 0;
  endfunction

  // first slot holding a key not below the given one
  function int lower_slot(logic [skset_pkg::FIELD_W-1:0] key);
    int slot;
    slot = 0;
    while (slot < stored_keys.size() && stored_keys[slot] < key) slot++;
    return slot;
  endfunction

  function void push_result(logic [2:0] status, logic [skset_pkg::FIELD_W-1:0] key,
                            logic has_key, logic last);
    skset_pkg::out_req_t res;
    res.status  = status;
    res.key_out = key;
    res.has_key = has_key;
    res.last    = last;
    pending_results.push_back(res);
  endfunction

  // work out the results of one accepted request
  function void note_request(skset_pkg::in_req_t req);
    logic [skset_pkg::FIELD_W-1:0] key;
    int slot;
    bit found;
    key   = req.name_key & key_mask;
    slot  = lower_slot(key);
    found = slot < stored_keys.size() && stored_keys[slot] == key;
    case (req.command)
      skset_pkg::CMD_ENTER: begin
        if (found) begin
          push_result(skset_pkg::ST_DUP, '0, 1'b0, 1'b1);
        end else if (stored_keys.size() >= capacity) begin
          push_result(skset_pkg::ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          stored_keys.insert(slot, key);
          push_result(skset_pkg::ST_DONE, '0, 1'b0, 1'b1);
        end
      end
      skset_pkg::CMD_LEAVE: begin
        if (found) begin
          stored_keys.delete(slot);
          push_result(skset_pkg::ST_DONE, '0, 1'b0, 1'b1);
        end else begin
          push_result(skset_pkg::ST_NOT_FOUND, '0, 1'b0, 1'b1);
        end
      end
      skset_pkg::CMD_REPORT: begin
        // empty set still gives one closing entry
        if (stored_keys.size() == 0) begin
          push_result(skset_pkg::ST_ENTRY, '0, 1'b0, 1'b1);
        end else begin
          for (int i = stored_keys.size() - 1; i >= 0; i--) begin
            push_result(skset_pkg::ST_ENTRY, stored_keys[i], 1'b1, i == 0);
          end
        end
      end
      default: begin
        push_result(skset_pkg::ST_DONE, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(skset_pkg::out_req_t got);
    skset_pkg::out_req_t exp;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d key_out %h", got.status, got.key_out);
      n_errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      n_errors++;
    end
    if (got.key_out !== exp.key_out) begin
      $error("key_out: expected %h, got %h", exp.key_out, got.key_out);
      n_errors++;
    end
    if (got.has_key !== exp.has_key) begin
      $error("has_key: expected %0b, got %0b", exp.has_key, got.has_key);
      n_errors++;
    end
    if (got.last !== exp.last) begin
      $error("last: expected %0b, got %0b", exp.last, got.last);
      n_errors++;
    end
  endfunction
endclass

module sorted_key_set_top_tb;
  import skset_pkg::*;

  localparam int          Capacity   = 32;
  localparam int          NameChars  = 5;
  localparam int          NumRandom  = 335;
  localparam int          PoolSize   = 48;
  localparam int          PhaseLen   = 80;
  localparam int          HoldAfter  = 120;
  localparam int          HoldCycles = 400;
  localparam int          MaxCycles  = 3000000;
  localparam logic [1:0]  CmdNoop    = 2'd3;
  localparam logic [FIELD_W-1:0] KeyMax = {FIELD_W{1'b1}};

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  in_req_t  in_req_i    = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  out_req_t out_req_o;

  sorted_set_predictor predictor = new(Capacity, NameChars);
  int unsigned n_accepted  = 0;
  int unsigned cycle_count = 0;
  logic [FIELD_W-1:0] name_pool[PoolSize];

  sorted_key_set_top #(
    .CAPACITY  (Capacity),
    .NAME_CHARS(NameChars)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predictor.note_request(in_req_i);
      n_accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      predictor.check_result(out_req_o);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("** sorted_key_set_top: FAILED **");
      $finish;
    end
  end

  // random idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // offer one request, hold it until taken, then idle for a random gap unless no_gap is set
  task automatic send_request(logic [1:0] cmd, logic [FIELD_W-1:0] key, bit no_gap);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    in_req_i.command  <= cmd;
    in_req_i.name_key <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = no_gap ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // receiver stall pattern, with one long hold-off once traffic is going
  initial begin
    bit held;
    int unsigned pick;
    int unsigned len;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && n_accepted >= HoldAfter) begin
        held = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // stretch with no stall
          len = $urandom_range(30, 1);
          @(negedge clk_i);
          out_stall_i <= 1'b0;
          repeat (len - 1) @(negedge clk_i);
        end else if (pick < 95) begin
          @(negedge clk_i);
          out_stall_i <= $urandom_range(1);
        end else begin
          len = (pick < 98) ? $urandom_range(8, 2) : $urandom_range(50, 20);
          @(negedge clk_i);
          out_stall_i <= 1'b1;
          repeat (len - 1) @(negedge clk_i);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned phase;
    int unsigned pick;
    logic [1:0] cmd;
    logic [FIELD_W-1:0] key;

    foreach (name_pool[i]) name_pool[i] = FIELD_W'($urandom());
    name_pool[0] = '0;
    name_pool[1] = KeyMax;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty set, key extremes, duplicates, absent keys, unused code
    send_request(CMD_REPORT, '0, 1'b0);
    send_request(CMD_LEAVE, 30'h0104_1041, 1'b0);
    send_request(CMD_ENTER, '0, 1'b0);
    send_request(CMD_ENTER, KeyMax, 1'b1);
    send_request(CMD_ENTER, '0, 1'b1);
    send_request(CMD_ENTER, 30'h0104_1041, 1'b0);
    send_request(CMD_ENTER, KeyMax, 1'b0);
    send_request(CMD_ENTER, 30'h1B6D_B6DB, 1'b1);
    send_request(CMD_REPORT, '0, 1'b1);
    send_request(CMD_LEAVE, KeyMax, 1'b0);
    send_request(CMD_LEAVE, KeyMax, 1'b0);
    send_request(CmdNoop, KeyMax, 1'b1);
    send_request(CmdNoop, '0, 1'b0);
    send_request(CMD_REPORT, KeyMax, 1'b0);
    send_request(CMD_LEAVE, '0, 1'b1);
    send_request(CMD_LEAVE, 30'h1B6D_B6DB, 1'b0);
    send_request(CMD_LEAVE, 30'h0104_1041, 1'b0);
    send_request(CMD_REPORT, '0, 1'b0);
    send_request(CMD_ENTER, 30'h2AAA_AAAA, 1'b1);
    send_request(CMD_ENTER, 30'h1555_5555, 1'b1);
    send_request(CMD_REPORT, '0, 1'b0);

    // random: phases lean toward filling, draining, then a mix
    for (int n = 0; n < NumRandom; n++) begin
      phase = (n / PhaseLen) % 3;
      pick  = $urandom_range(99);
      case (phase)
        0:       cmd = (pick < 75) ? CMD_ENTER : (pick < 83) ? CMD_LEAVE :
                       (pick < 96) ? CMD_REPORT : CmdNoop;
        1:       cmd = (pick < 15) ? CMD_ENTER : (pick < 80) ? CMD_LEAVE :
                       (pick < 96) ? CMD_REPORT : CmdNoop;
        default: cmd = (pick < 40) ? CMD_ENTER : (pick < 75) ? CMD_LEAVE :
                       (pick < 95) ? CMD_REPORT : CmdNoop;
      endcase
      key = ($urandom_range(99) < 85) ? name_pool[$urandom_range(PoolSize - 1)]
                                      : FIELD_W'($urandom());
      send_request(cmd, key, ($urandom_range(99) < 20));
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then allow for a full report worth of extra cycles
    while (predictor.pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * Capacity + 10) @(posedge clk_i);

    if (predictor.pending_results.size() != 0) begin
      $error("%0d results never arrived", predictor.pending_results.size());
      predictor.n_errors++;
    end
    if (predictor.n_errors == 0) begin
      $display("** sorted_key_set_top: PASSED **");
    end else begin
      $display("** sorted_key_set_top: FAILED **");
    end
    $finish;
  end

endmodule
